// ----- hw/rtl/hbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared sizes, register codes and counter helpers of the hybrid predictor.
// ----------------------------------------------------------------------------
package hbp_pkg;

    localparam int MAX_INDEX_BITS   = 14;
    localparam int MAX_CHOOSER_BITS = 14;
    localparam int COUNTER_WIDTH    = 3;

    localparam int IDX_W   = MAX_INDEX_BITS;
    localparam int CHS_W   = MAX_CHOOSER_BITS;
    localparam int CLR_W   = (IDX_W > CHS_W) ? IDX_W : CHS_W;
    localparam int TBL_SZ  = 1 << IDX_W;
    localparam int CHS_SZ  = 1 << CHS_W;

    localparam logic [COUNTER_WIDTH-1:0] CTR_MAX  = {COUNTER_WIDTH{1'b1}};
    localparam logic [COUNTER_WIDTH-1:0] CTR_INIT =
        COUNTER_WIDTH'(1 << (COUNTER_WIDTH - 1));
    localparam logic [1:0] CHS_INIT = 2'd1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GSH_BITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIM_BITS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHS_BITS  = 3'd4;
    localparam int CFG_DATA_W = 4;

    // predictor modes, any other code acts as hybrid
    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_HYBRID  = 2'd2;

    function automatic logic [7:0] clamp_bits(input logic [7:0] v, input logic [7:0] mx);
        clamp_bits = (v > mx) ? mx : v;
    endfunction

    function automatic logic [IDX_W-1:0] idx_mask(input logic [7:0] bits);
        idx_mask = {IDX_W{1'b1}} >> (8'(IDX_W) - bits);
    endfunction

    function automatic logic [CHS_W-1:0] chs_mask(input logic [7:0] bits);
        chs_mask = {CHS_W{1'b1}} >> (8'(CHS_W) - bits);
    endfunction

    function automatic logic [COUNTER_WIDTH-1:0] ctr_train(
        input logic [COUNTER_WIDTH-1:0] c, input logic up);
        if (up) begin
            ctr_train = (c != CTR_MAX) ? c + 1'b1 : c;
        end else begin
            ctr_train = (c != '0) ? c - 1'b1 : c;
        end
    endfunction

    function automatic logic [1:0] chs_train(input logic [1:0] c, input logic up);
        if (up) begin
            chs_train = (c != 2'd3) ? c + 2'd1 : c;
        end else begin
            chs_train = (c != 2'd0) ? c - 2'd1 : c;
        end
    endfunction

endpackage

// ----- hw/rtl/hybrid_branch_predictor.sv -----
`timescale 1ns / 1ps
// pipeline: inputs register into stage 1, then into the result register
// throughput: one branch per cycle while o_in_ready holds; tables are read on the
//   input transfer, written back as stage 1 advances, with back-to-back bypass
// reset: synchronous; a clearing pass over 2^14 entries fills all three tables,
//   with o_in_ready low until it is done (configuration writes are taken)
// ----------------------------------------------------------------------------
// hybrid_branch_predictor
// Gshare/bimodal tournament predictor with a per-pc chooser, or either one alone.
// ----------------------------------------------------------------------------
module hybrid_branch_predictor
    import hbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_branch_pc,
    input  logic                  i_taken,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_predicted_taken,
    output logic                  o_mispredicted,
    output logic                  o_chose_gshare,
    output logic [31:0]           o_prediction_total,
    output logic [31:0]           o_misprediction_total
);

    // configuration
    logic [1:0]            r_cfg_mode;
    logic [CFG_DATA_W-1:0] r_cfg_gbits, r_cfg_hlen, r_cfg_mbits, r_cfg_kbits;

    // clearing pass
    logic             r_clearing;
    logic [CLR_W-1:0] r_clr_addr;

    // tables
    logic [COUNTER_WIDTH-1:0] r_gsh_mem [TBL_SZ];
    logic [COUNTER_WIDTH-1:0] r_bim_mem [TBL_SZ];
    logic [1:0]               r_chs_mem [CHS_SZ];
    logic [COUNTER_WIDTH-1:0] r_g_rd, r_b_rd;
    logic [1:0]               r_c_rd;

    // bypass of the most recent write to each table
    logic                     r_fwg_vld, r_fwb_vld, r_fwc_vld;
    logic [IDX_W-1:0]         r_fwg_addr, r_fwb_addr;
    logic [CHS_W-1:0]         r_fwc_addr;
    logic [COUNTER_WIDTH-1:0] r_fwg_data, r_fwb_data;
    logic [1:0]               r_fwc_data;

    logic [IDX_W-1:0] r_hist;

    // stage 1
    logic             r_s1_vld, r_s1_taken;
    logic [IDX_W-1:0] r_s1_gi, r_s1_bi;
    logic [CHS_W-1:0] r_s1_ci;

    // totals and result register
    logic [31:0] r_pred_total, r_miss_total;
    logic [31:0] n_pred_total, n_miss_total;
    logic        r_out_vld, r_out_pred, r_out_miss, r_out_useg;
    logic [31:0] r_out_ptot, r_out_mtot;

    logic in_xfer, s1_adv;
    logic [7:0] g_bits, n_bits, m_bits, k_bits;
    logic [IDX_W-1:0] pc_idx, hist_sh, gi, bi;
    logic [CHS_W-1:0] pc_chs, ci;

    logic [COUNTER_WIDTH-1:0] g_ctr, b_ctr, g_new, b_new;
    logic [1:0] c_ctr, c_new;
    logic gp, bp, use_g, pred, miss, chs_upd;

    logic                     g_we, b_we, c_we;
    logic [IDX_W-1:0]         g_waddr, b_waddr;
    logic [CHS_W-1:0]         c_waddr;
    logic [COUNTER_WIDTH-1:0] g_wdata, b_wdata;
    logic [1:0]               c_wdata;

    assign o_cfg_ready = 1'b1;
    assign s1_adv      = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_clearing && (!r_s1_vld || s1_adv);
    assign in_xfer     = i_in_valid && o_in_ready;

    // ---- index generation on the incoming branch ----
    always_comb begin
        g_bits  = clamp_bits(8'(r_cfg_gbits), 8'(MAX_INDEX_BITS));
        n_bits  = clamp_bits(8'(r_cfg_hlen), g_bits);
        m_bits  = clamp_bits(8'(r_cfg_mbits), 8'(MAX_INDEX_BITS));
        k_bits  = clamp_bits(8'(r_cfg_kbits), 8'(MAX_CHOOSER_BITS));
        pc_idx  = i_branch_pc[IDX_W+1:2];
        pc_chs  = i_branch_pc[CHS_W+1:2];
        hist_sh = r_hist >> (8'(MAX_INDEX_BITS) - n_bits);
        gi      = (pc_idx & idx_mask(g_bits)) ^ hist_sh;
        bi      = pc_idx & idx_mask(m_bits);
        ci      = pc_chs & chs_mask(k_bits);
    end

    // ---- prediction and training in stage 1 ----
    always_comb begin
        g_ctr = (r_fwg_vld && r_fwg_addr == r_s1_gi) ? r_fwg_data : r_g_rd;
        b_ctr = (r_fwb_vld && r_fwb_addr == r_s1_bi) ? r_fwb_data : r_b_rd;
        c_ctr = (r_fwc_vld && r_fwc_addr == r_s1_ci) ? r_fwc_data : r_c_rd;
        gp    = g_ctr[COUNTER_WIDTH-1];
        bp    = b_ctr[COUNTER_WIDTH-1];
        if (r_cfg_mode == MODE_BIMODAL) begin
            use_g = 1'b0;
        end else if (r_cfg_mode == MODE_GSHARE) begin
            use_g = 1'b1;
        end else begin
            use_g = c_ctr[1];
        end
        pred    = use_g ? gp : bp;
        miss    = pred != r_s1_taken;
        chs_upd = (r_cfg_mode != MODE_BIMODAL) && (r_cfg_mode != MODE_GSHARE) && (gp != bp);
        g_new   = ctr_train(g_ctr, r_s1_taken);
        b_new   = ctr_train(b_ctr, r_s1_taken);
        c_new   = chs_train(c_ctr, gp == r_s1_taken);

        n_pred_total = (r_pred_total != 32'hFFFF_FFFF) ? r_pred_total + 32'd1 : r_pred_total;
        n_miss_total = (miss && r_miss_total != 32'hFFFF_FFFF) ?
                       r_miss_total + 32'd1 : r_miss_total;
    end

    // ---- table write ports, shared with the clearing pass ----
    always_comb begin
        g_we    = r_clearing || (s1_adv && use_g);
        b_we    = r_clearing || (s1_adv && !use_g);
        c_we    = r_clearing || (s1_adv && chs_upd);
        g_waddr = r_clearing ? r_clr_addr[IDX_W-1:0] : r_s1_gi;
        b_waddr = r_clearing ? r_clr_addr[IDX_W-1:0] : r_s1_bi;
        c_waddr = r_clearing ? r_clr_addr[CHS_W-1:0] : r_s1_ci;
        g_wdata = r_clearing ? CTR_INIT : g_new;
        b_wdata = r_clearing ? CTR_INIT : b_new;
        c_wdata = r_clearing ? CHS_INIT : c_new;
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_gsh_mem[g_waddr] <= g_wdata;
        end
        if (in_xfer) begin
            r_g_rd <= r_gsh_mem[gi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bim_mem[b_waddr] <= b_wdata;
        end
        if (in_xfer) begin
            r_b_rd <= r_bim_mem[bi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_chs_mem[c_waddr] <= c_wdata;
        end
        if (in_xfer) begin
            r_c_rd <= r_chs_mem[ci];
        end
    end

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode  <= MODE_HYBRID;
            r_cfg_gbits <= 4'd14;
            r_cfg_hlen  <= 4'd8;
            r_cfg_mbits <= 4'd14;
            r_cfg_kbits <= 4'd14;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:     r_cfg_mode  <= i_cfg_data[1:0];
                CFG_GSH_BITS: r_cfg_gbits <= i_cfg_data;
                CFG_HIST_LEN: r_cfg_hlen  <= i_cfg_data;
                CFG_BIM_BITS: r_cfg_mbits <= i_cfg_data;
                CFG_CHS_BITS: r_cfg_kbits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_hist       <= '0;
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_pred_total <= '0;
            r_miss_total <= '0;
            r_fwg_vld    <= 1'b0;
            r_fwb_vld    <= 1'b0;
            r_fwc_vld    <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == {CLR_W{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end
            // history only depends on the outcome, so it moves on the transfer
            if (in_xfer && r_cfg_mode != MODE_BIMODAL) begin
                r_hist <= {i_taken, r_hist[IDX_W-1:1]};
            end
            if (in_xfer) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld    <= 1'b1;
                r_pred_total <= n_pred_total;
                r_miss_total <= n_miss_total;
                if (use_g) begin
                    r_fwg_vld <= 1'b1;
                end else begin
                    r_fwb_vld <= 1'b1;
                end
                if (chs_upd) begin
                    r_fwc_vld <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_taken <= i_taken;
            r_s1_gi    <= gi;
            r_s1_bi    <= bi;
            r_s1_ci    <= ci;
        end
        if (s1_adv) begin
            r_out_pred <= pred;
            r_out_miss <= miss;
            r_out_useg <= use_g;
            r_out_ptot <= n_pred_total;
            r_out_mtot <= n_miss_total;
            if (use_g) begin
                r_fwg_addr <= r_s1_gi;
                r_fwg_data <= g_new;
            end else begin
                r_fwb_addr <= r_s1_bi;
                r_fwb_data <= b_new;
            end
            if (chs_upd) begin
                r_fwc_addr <= r_s1_ci;
                r_fwc_data <= c_new;
            end
        end
    end

    assign o_out_valid           = r_out_vld;
    assign o_predicted_taken     = r_out_pred;
    assign o_mispredicted        = r_out_miss;
    assign o_chose_gshare        = r_out_useg;
    assign o_prediction_total    = r_out_ptot;
    assign o_misprediction_total = r_out_mtot;

endmodule

// ----- hw/rtl/hbp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks on result ordering and running totals of the predictor.
// ----------------------------------------------------------------------------
module hbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_predicted_taken,
    input logic        o_mispredicted,
    input logic [31:0] o_prediction_total,
    input logic [31:0] o_misprediction_total
);

    logic        out_xfer;
    logic        r_seen;
    logic [31:0] r_last_ptot, r_last_mtot;

    assign out_xfer = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_ptot <= '0;
            r_last_mtot <= '0;
        end else if (out_xfer) begin
            r_seen      <= 1'b1;
            r_last_ptot <= o_prediction_total;
            r_last_mtot <= o_misprediction_total;
        end
    end

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_prediction_total)
            && $stable(o_predicted_taken) && $stable(o_mispredicted))
        else $error("result changed while stalled");

    // each transfer counts exactly one prediction
    a_ptot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen && r_last_ptot != 32'hFFFF_FFFF
            |-> o_prediction_total == r_last_ptot + 32'd1)
        else $error("prediction total skipped or repeated");

    a_ptot_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !r_seen |-> o_prediction_total == 32'd1)
        else $error("first prediction total wrong");

    // miss total moves with the mispredict flag
    a_mtot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen && r_last_mtot != 32'hFFFF_FFFF
            |-> o_misprediction_total == r_last_mtot + 32'(o_mispredicted))
        else $error("misprediction total out of step with flag");

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (.*);
